/* hw/rtl/pcot_pkg.sv */
package pcot_pkg;

  // Default table size.
  localparam int MaxPeersDef = 8;

  // Field widths.
  localparam int TimeW  = 32;
  localparam int NumW   = 8;
  localparam int Cfg16W = 16;

  // Stream payload widths and output bit positions.
  localparam int InDataW      = 144;
  localparam int OutDataW     = 72;
  localparam int OutUsedBit   = 0;
  localparam int OutSyncedBit = 1;
  localparam int OutForceBit  = 66;

  // Configuration port.
  localparam int CfgAddrW = 5;
  localparam int CfgDataW = 32;

  localparam logic [2:0] RegOwnNumber    = 3'd0;
  localparam logic [2:0] RegLowestPeer   = 3'd1;
  localparam logic [2:0] RegHighestPeer  = 3'd2;
  localparam logic [2:0] RegDriftDivider = 3'd3;
  localparam logic [2:0] RegMaxPktDelay  = 3'd4;

  localparam logic [7:0]  OwnNumberRst    = 8'd1;
  localparam logic [7:0]  LowestPeerRst   = 8'd1;
  localparam logic [7:0]  HighestPeerRst  = 8'd6;
  localparam logic [15:0] DriftDividerRst = 16'd1000;
  localparam logic [15:0] MaxPktDelayRst  = 16'd100;

  // One table entry as it sits in the memory.
  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] round_trip;
    logic [31:0] sync_time;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // Request to the serial divider.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

endpackage

/* hw/rtl/pcot_ram.sv */
module pcot_ram #(
  parameter int Width = 8,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AddrW-1:0]         waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [AddrW-1:0]         raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/pcot_div.sv */
module pcot_div (
  input  logic                clk,
  input  logic                rst_n,
  input  pcot_pkg::div_req_t  req,
  output logic                done,
  output logic [31:0]         quotient
);

  localparam int Steps = 32;
  localparam int CntW  = $clog2(Steps + 1);

  logic [15:0]     divisor_r;
  logic [15:0]     rem_r;
  logic [31:0]     quo_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic [16:0]     trial;
  logic            fits;

  // Restoring division, one quotient bit per cycle. A zero divisor always
  // fits, so the quotient comes out as all ones.
  assign trial = {rem_r, quo_r[31]};
  assign fits  = trial >= {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CntW'(Steps);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor_r <= req.divisor;
      rem_r     <= '0;
      quo_r     <= req.dividend;
    end else if (busy_r) begin
      rem_r <= fits ? 16'(trial - {1'b0, divisor_r}) : trial[15:0];
      quo_r <= {quo_r[30:0], fits};
    end
  end

  assign done     = busy_r && (cnt_r == CntW'(1));
  assign quotient = quo_r;

endmodule

/* hw/rtl/peer_clock_offset_tracker.sv */
// An accepted item passes READ, DIV, CHK1-CHK3, MRG1, MRG2 and DONE before
// out_tvalid; a rejected sender goes straight to DONE. One item is taken at a time;
// the 32-step serial divider for the drift bound takes most of the time per item.
// A stalled output holds the write-back until the result register is free.
// Reset (synchronous, rst_n low) clears the entry valid bits, so every peer
// reads as unsynced, and loads the configuration registers with their defaults.
module peer_clock_offset_tracker #(
  parameter int MAX_PEERS = pcot_pkg::MaxPeersDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: sender_number, remote_send_time, local_receive_time,
  // response_receiver, request_origin_time, request_receipt_time
  input  logic [pcot_pkg::InDataW-1:0]    in_tdata,
  // tuser: has_response
  input  logic                            in_tuser,
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: response_used, peer_synced, peer_offset, peer_round_trip,
  // force_request, zero padding
  output logic [pcot_pkg::OutDataW-1:0]   out_tdata,
  // tuser: status
  output logic                            out_tuser,
  // Configuration port.
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [pcot_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  logic [pcot_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic [pcot_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                            cfg_pready
);

  localparam int IdxW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_CHK1 = 4'd3;
  localparam logic [3:0] S_CHK2 = 4'd4;
  localparam logic [3:0] S_CHK3 = 4'd5;
  localparam logic [3:0] S_MRG1 = 4'd6;
  localparam logic [3:0] S_MRG2 = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  // Configuration registers.
  logic [7:0]  own_r, lowest_r, highest_r;
  logic [15:0] drift_div_r, max_delay_r;
  logic        cfg_wr;

  // Control.
  logic [3:0]           state_r, state_nxt;
  logic [MAX_PEERS-1:0] vld_r;
  logic                 out_valid_r;
  logic [pcot_pkg::OutDataW-1:0] out_data_r;
  logic                 out_user_r;

  // Item fields.
  logic [7:0]      in_sender, in_rcvr;
  logic [31:0]     in_send, in_recv, in_orig, in_rcpt;
  logic [7:0]      sender_diff;
  logic            in_reject;
  logic            accept;
  logic            can_out;

  logic [31:0]     send_r, recv_r, orig_r, rcpt_r;
  logic [7:0]      rcvr_r;
  logic            has_resp_r, reject_r;
  logic [IdxW-1:0] idx_r;

  // Working registers.
  logic [31:0] off_r, rt_r, ts_r, halfrt_r;
  logic [31:0] ta_r, tb_r, total_r, proc_r, sum_r, rtnew_r, half_r;
  logic [31:0] exact_r, bound_r, lo_r, hi_r, lim1_r, mag_r;
  logic        resp_ok_r, used_r, unsync_r, replace_r;

  // Combinational helpers.
  pcot_pkg::entry_t    ram_rdata, ent, new_ent;
  pcot_pkg::div_req_t  div_req;
  logic                div_done;
  logic [31:0]         div_quo;
  logic [31:0]         ts_span, rt_inc, sum_adj, diff, sum2;
  logic                new_synced;

  // Field unpacking.
  assign in_sender = in_tdata[7:0];
  assign in_send   = in_tdata[39:8];
  assign in_recv   = in_tdata[71:40];
  assign in_rcvr   = in_tdata[79:72];
  assign in_orig   = in_tdata[111:80];
  assign in_rcpt   = in_tdata[143:112];

  // Sender range check against the configured window and the table size.
  assign sender_diff = in_sender - lowest_r;
  assign in_reject   = (in_sender < lowest_r) || (in_sender > highest_r) ||
                       (sender_diff >= 8'(MAX_PEERS));

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign can_out   = !out_valid_r || out_tready;

  // Configuration writes and reads.
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r       <= pcot_pkg::OwnNumberRst;
      lowest_r    <= pcot_pkg::LowestPeerRst;
      highest_r   <= pcot_pkg::HighestPeerRst;
      drift_div_r <= pcot_pkg::DriftDividerRst;
      max_delay_r <= pcot_pkg::MaxPktDelayRst;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        pcot_pkg::RegOwnNumber:    own_r       <= cfg_pwdata[7:0];
        pcot_pkg::RegLowestPeer:   lowest_r    <= cfg_pwdata[7:0];
        pcot_pkg::RegHighestPeer:  highest_r   <= cfg_pwdata[7:0];
        pcot_pkg::RegDriftDivider: drift_div_r <= cfg_pwdata[15:0];
        pcot_pkg::RegMaxPktDelay:  max_delay_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      pcot_pkg::RegOwnNumber:    cfg_prdata = {24'd0, own_r};
      pcot_pkg::RegLowestPeer:   cfg_prdata = {24'd0, lowest_r};
      pcot_pkg::RegHighestPeer:  cfg_prdata = {24'd0, highest_r};
      pcot_pkg::RegDriftDivider: cfg_prdata = {16'd0, drift_div_r};
      pcot_pkg::RegMaxPktDelay:  cfg_prdata = {16'd0, max_delay_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  // Entry memory; an entry never written reads as zero through its valid bit.
  pcot_ram #(
    .Width (pcot_pkg::EntryW),
    .Depth (MAX_PEERS)
  ) u_pcot_ram (
    .clk   (clk),
    .we    ((state_r == S_DONE) && can_out && !reject_r),
    .waddr (idx_r),
    .wdata (new_ent),
    .re    (accept),
    .raddr (sender_diff[IdxW-1:0]),
    .rdata (ram_rdata)
  );

  assign ent = vld_r[idx_r] ? ram_rdata : '0;

  // Drift bound: twice the elapsed time since the sync, over the divider.
  assign ts_span          = recv_r - ent.sync_time;
  assign div_req.start    = (state_r == S_READ);
  assign div_req.dividend = {ts_span[30:0], 1'b0};
  assign div_req.divisor  = drift_div_r;

  pcot_div u_pcot_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = in_reject ? S_DONE : S_READ;
      S_READ: state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = S_CHK1;
      S_CHK1: state_nxt = S_CHK2;
      S_CHK2: state_nxt = S_CHK3;
      S_CHK3: state_nxt = S_MRG1;
      S_MRG1: state_nxt = S_MRG2;
      S_MRG2: state_nxt = S_DONE;
      S_DONE: if (can_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Arithmetic helpers for the working stages.
  assign rt_inc  = ent.round_trip + 32'd1;
  assign sum_adj = sum_r + {31'd0, sum_r[31]};
  assign diff    = half_r - off_r;
  assign sum2    = rtnew_r + lim1_r;

  // Replace the entry or keep it with its sync time possibly cleared.
  always_comb begin
    if (used_r && replace_r) begin
      new_ent.offset     = half_r;
      new_ent.round_trip = rtnew_r;
      new_ent.sync_time  = recv_r;
    end else begin
      new_ent.offset     = off_r;
      new_ent.round_trip = rt_r;
      new_ent.sync_time  = unsync_r ? 32'd0 : ts_r;
    end
  end

  assign new_synced = (new_ent.sync_time != 32'd0);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_DONE) && can_out) begin
        out_valid_r <= 1'b1;
        if (!reject_r) begin
          vld_r[idx_r] <= 1'b1;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers, loaded stage by stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      send_r     <= in_send;
      recv_r     <= in_recv;
      orig_r     <= in_orig;
      rcpt_r     <= in_rcpt;
      rcvr_r     <= in_rcvr;
      has_resp_r <= in_tuser;
      reject_r   <= in_reject;
      idx_r      <= sender_diff[IdxW-1:0];
    end
    if (state_r == S_READ) begin
      off_r     <= ent.offset;
      rt_r      <= ent.round_trip;
      ts_r      <= ent.sync_time;
      halfrt_r  <= {1'b0, rt_inc[31:1]};
      ta_r      <= rcpt_r - orig_r;
      tb_r      <= send_r - recv_r;
      total_r   <= recv_r - orig_r;
      proc_r    <= send_r - rcpt_r;
      resp_ok_r <= has_resp_r && (rcvr_r == own_r) &&
                   (recv_r >= orig_r) && (send_r >= rcpt_r);
    end
    if (state_r == S_CHK1) begin
      exact_r <= recv_r + off_r;
      bound_r <= halfrt_r + div_quo;
      sum_r   <= ta_r + tb_r;
      rtnew_r <= total_r - proc_r;
      used_r  <= resp_ok_r && (proc_r <= total_r);
    end
    if (state_r == S_CHK2) begin
      lo_r   <= exact_r - bound_r - {16'd0, max_delay_r};
      hi_r   <= exact_r + bound_r;
      half_r <= {sum_adj[31], sum_adj[31:1]};
    end
    if (state_r == S_CHK3) begin
      unsync_r <= (ts_r == 32'd0) || (send_r < lo_r) || (send_r > hi_r);
    end
    if (state_r == S_MRG1) begin
      lim1_r <= rt_r + {div_quo[30:0], 1'b0};
      mag_r  <= diff[31] ? (32'd0 - diff) : diff;
    end
    if (state_r == S_MRG2) begin
      replace_r <= unsync_r || (rtnew_r < lim1_r) || ({mag_r[30:0], 1'b0} > sum2);
    end
    if ((state_r == S_DONE) && can_out) begin
      out_user_r <= reject_r;
      if (reject_r) begin
        out_data_r <= '0;
      end else begin
        out_data_r <= {5'd0, !new_synced, new_ent.round_trip, new_ent.offset,
                       new_synced, used_r};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* hw/rtl/pcot_checker.sv */
module pcot_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pcot_pkg::OutDataW-1:0]   out_tdata,
  input logic                            out_tuser
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A rejected sender reports nothing but its status.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("rejected item carries payload");

  // A processed item asks for a request exactly when its peer is unsynced.
  a_force_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[pcot_pkg::OutForceBit] != out_tdata[pcot_pkg::OutSyncedBit])
    else $error("force_request disagrees with peer_synced");

  // One item at a time: the block is busy right after it takes an item.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

endmodule

bind peer_clock_offset_tracker pcot_checker u_pcot_checker (.*);
